### hw/rtl/source_connection_rate_limiter_core_macros.svh
// Assertion macros shared by the rate limiter RTL.
`ifndef SOURCE_CONNECTION_RATE_LIMITER_CORE_MACROS_SVH
`define SOURCE_CONNECTION_RATE_LIMITER_CORE_MACROS_SVH
`ifndef SYNTH
`define SCRL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("scrl check failed");
`define SCRL_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`else
`define SCRL_ASSERT(lbl, prop)
`define SCRL_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

### hw/rtl/scrl_pkg.sv
// Types, constants and helpers for the connection rate limiter.
`timescale 1ns / 1ps
package scrl_pkg;
	localparam int TABLE_ENTRIES = 512;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	localparam logic [7:0] REG_EXPIRY    = 8'd0;
	localparam logic [7:0] REG_SCORE_LIM = 8'd1;
	localparam logic [7:0] REG_COUNT_LIM = 8'd2;
	localparam logic [7:0] REG_SCORE_INC = 8'd3;

	typedef struct packed {
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [31:0] now_seconds;
	} in_t;

	typedef struct packed {
		logic       verdict;
		logic       newly_banned;
		logic       matched;
		logic [8:0] slot;
	} out_t;

	typedef struct packed {
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [31:0] etime;
		logic [15:0] escore;
		logic [15:0] ecount;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic is_banned(input logic [15:0] score, input logic [15:0] count,
					   input logic [9:0] slim, input logic [15:0] clim);
		is_banned = (score > {slim, 6'b0}) && (count > clim);
	endfunction
endpackage

### hw/rtl/scrl_ram.sv
// Generic single-write, single-read RAM with a registered read.
`timescale 1ns / 1ps
module scrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/source_connection_rate_limiter_core.sv
// Top level of the per-source connection rate limiter.
`timescale 1ns / 1ps
// Each input transaction is one connection attempt (128-bit source address and the time in
// seconds) and yields exactly one output transaction: accept or reject, whether the attempt
// caused a fresh ban, whether the source was already known, and the table slot used. The
// source table lives in one synchronous RAM of TABLE_ENTRIES entries that is walked from slot
// zero upward; each slot has an address step and then a check of the registered read data,
// during which stale or future-dated entries are emptied and the replacement victim is tracked,
// so no second pass is needed. A miss walks every slot; a hit ends the walk, and unless the
// source is already banned its score then runs through the bit-serial score divider. One
// attempt is handled at a time. After reset the block sweeps zeros through the RAM, one entry
// per cycle, and accepts no attempt until that is done; configuration writes are taken at all
// times but must only be issued while the block is idle. The result sits in an output
// register, so the next attempt may start while the previous result still waits to be taken.
`include "source_connection_rate_limiter_core_macros.svh"
module source_connection_rate_limiter_core import scrl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_CHK   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_UPD   = 3'd5;
	localparam logic [2:0] ST_ALLOC = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

	logic [2:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	in_t              in_q;
	logic [15:0]      exp_q;
	logic [9:0]       slim_q;
	logic [15:0]      clim_q;
	logic [9:0]       inc_q;

	// Entry that was hit, and the divider working registers.
	entry_t      ent_q;
	logic        was_q;
	logic [17:0] rem_q;
	logic [20:0] quo_q;
	logic [16:0] dvs_q;
	logic [4:0]  cnt_q;

	// Victim candidates: oldest unbanned entry and oldest entry overall.
	logic             vu_found_q;
	logic [31:0]      vu_time_q;
	logic [IDX_W-1:0] vu_idx_q;
	logic             va_found_q;
	logic [31:0]      va_time_q;
	logic [IDX_W-1:0] va_idx_q;

	out_t res_q;
	out_t out_q;
	logic out_valid_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	entry_t           rd;

	scrl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (rd)
	);

	// Checks on the entry just read back.
	logic        live, expired, match, hit, rd_banned, vban;
	logic [31:0] age, vtime;
	always_comb begin
		live      = rd.etime != 32'd0;
		age       = in_q.now_seconds - rd.etime;
		expired   = live && ((in_q.now_seconds < rd.etime) || (age > 32'(exp_q)));
		match     = (rd.addr_high == in_q.addr_high) && (rd.addr_low == in_q.addr_low);
		hit       = live && !expired && match;
		rd_banned = is_banned(rd.escore, rd.ecount, slim_q, clim_q);
		vtime     = expired ? 32'd0 : rd.etime;
		vban      = expired ? 1'b0 : rd_banned;
	end

	// One restoring division step per cycle.
	logic [17:0] trial;
	logic        qbit;
	always_comb begin
		trial = {rem_q[16:0], quo_q[20]};
		qbit  = trial >= {1'b0, dvs_q};
	end

	// Score and count update for a hit.
	logic [21:0]      ssum;
	logic [15:0]      new_score, new_count;
	logic             now_banned;
	logic [IDX_W-1:0] victim;
	always_comb begin
		ssum       = 22'(quo_q) + 22'({inc_q, 6'b0});
		new_score  = was_q ? ent_q.escore : ((|ssum[21:16]) ? 16'hFFFF : ssum[15:0]);
		new_count  = (ent_q.ecount == 16'hFFFF) ? ent_q.ecount : ent_q.ecount + 16'd1;
		now_banned = is_banned(new_score, new_count, slim_q, clim_q);
		victim     = vu_found_q ? vu_idx_q : va_idx_q;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
			end
			ST_CHK: begin
				// An emptied entry keeps its address but loses time, score and count.
				ram_we              = expired;
				ram_wdata.addr_high = rd.addr_high;
				ram_wdata.addr_low  = rd.addr_low;
			end
			ST_UPD: begin
				ram_we           = 1'b1;
				ram_wdata        = ent_q;
				ram_wdata.escore = new_score;
				ram_wdata.ecount = new_count;
				ram_wdata.etime  = now_banned ? ent_q.etime : in_q.now_seconds;
			end
			ST_ALLOC: begin
				ram_we              = 1'b1;
				ram_waddr           = victim;
				ram_wdata.addr_high = in_q.addr_high;
				ram_wdata.addr_low  = in_q.addr_low;
				ram_wdata.etime     = in_q.now_seconds;
				ram_wdata.ecount    = 16'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			idx_q       <= '0;
			exp_q       <= 16'd300;
			slim_q      <= 10'd100;
			clim_q      <= 16'd7;
			inc_q       <= 10'd30;
			out_valid_q <= 1'b0;
			vu_found_q  <= 1'b0;
			va_found_q  <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_EXPIRY:    exp_q  <= cfg_data;
					REG_SCORE_LIM: slim_q <= cfg_data[9:0];
					REG_COUNT_LIM: clim_q <= cfg_data;
					REG_SCORE_INC: inc_q  <= cfg_data[9:0];
					default: begin
					end
				endcase
			end
			// In the final state a taken result is replaced by the new one below.
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						in_q       <= in_data;
						idx_q      <= '0;
						vu_found_q <= 1'b0;
						va_found_q <= 1'b0;
						state_q    <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (hit) begin
						ent_q   <= rd;
						was_q   <= rd_banned;
						rem_q   <= '0;
						quo_q   <= 21'({rd.escore, 4'b0}) + 21'({rd.escore, 2'b0});
						dvs_q   <= 17'(age[15:0]) + 17'd15;
						cnt_q   <= '0;
						state_q <= rd_banned ? ST_UPD : ST_DIV;
					end else begin
						if (!vban && (!vu_found_q || vtime < vu_time_q)) begin
							vu_found_q <= 1'b1;
							vu_time_q  <= vtime;
							vu_idx_q   <= idx_q;
						end
						if (!va_found_q || vtime < va_time_q) begin
							va_found_q <= 1'b1;
							va_time_q  <= vtime;
							va_idx_q   <= idx_q;
						end
						if (idx_q == IDX_LAST) begin
							state_q <= ST_ALLOC;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_DIV: begin
					rem_q <= qbit ? trial - {1'b0, dvs_q} : trial;
					quo_q <= {quo_q[19:0], qbit};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd20) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					res_q.verdict      <= now_banned;
					res_q.newly_banned <= now_banned && !was_q;
					res_q.matched      <= 1'b1;
					res_q.slot         <= 9'(idx_q);
					state_q            <= ST_DONE;
				end
				ST_ALLOC: begin
					res_q.verdict      <= 1'b0;
					res_q.newly_banned <= 1'b0;
					res_q.matched      <= 1'b0;
					res_q.slot         <= 9'(victim);
					state_q            <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SCRL_ASSERT(a_no_write_idle, (state_q == ST_IDLE) |-> !ram_we)
	`SCRL_ASSERT(a_start_scan, (in_valid && in_ready) |=> (state_q == ST_RD && idx_q == '0))
	`SCRL_ASSERT(a_result_from_done, $rose(out_valid) |-> $past(state_q == ST_DONE))
	`SCRL_ASSERT_MSG(a_reject_matched, out_valid |-> (!out_data.verdict || out_data.matched),
		"reject without a table hit")
	`SCRL_ASSERT_MSG(a_fresh_is_reject, out_valid |-> (!out_data.newly_banned || out_data.verdict),
		"fresh ban without reject")
endmodule
